FILE: rtl/core/kfpa_pkg.sv
package kfpa_pkg;

   localparam int ADDR_W = 19;
   // one bit of headroom for the row offset before the final wrap
   localparam int SUM_W  = ADDR_W + 1;

   typedef enum logic [2:0] {
      OP_CODE_LO  = 3'd0,
      OP_CODE_HI  = 3'd1,
      OP_ROW      = 3'd2,
      OP_READ     = 3'd3,
      OP_WRITE    = 3'd4
   } op_type;

   localparam logic [1:0] TGT_ROM    = 2'd0;
   localparam logic [1:0] TGT_BACKUP = 2'd1;
   localparam logic [1:0] TGT_BLANK  = 2'd2;

   localparam logic [SUM_W-1:0] ANK8_BASE   = SUM_W'(32'h41000);
   localparam logic [SUM_W-1:0] ANK16_BASE  = SUM_W'(32'h40000);
   localparam logic [SUM_W-1:0] NONKANJI_B  = SUM_W'(32'h40000);
   localparam logic [SUM_W-1:0] LEVEL1_HI   = SUM_W'(32'h04000);
   localparam logic [SUM_W-1:0] LEVEL2_BASE = SUM_W'(32'h20000);
   localparam logic [SUM_W-1:0] LEVEL2_HI   = SUM_W'(32'h24000);

   localparam logic [7:0] JIS1_OFFSET = 8'h20;
   localparam logic [6:0] BLANK_JIS2A = 7'h7e;
   localparam logic [6:0] BLANK_JIS2B = 7'h7f;

   typedef struct packed {
      logic [1:0]        target;
      logic [ADDR_W-1:0] byte_address;
      logic              writable;
   } map_result_type;

endpackage

FILE: rtl/core/kfpa_if.sv
interface kfpa_req_if;
   import kfpa_pkg::*;

   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] data;

   modport source (output valid, output operation, output data, input ready);
   modport sink (input valid, input operation, input data, output ready);
endinterface

interface kfpa_rsp_if;
   import kfpa_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        target;
   logic [ADDR_W-1:0] byte_address;
   logic              is_write;
   logic [7:0]        write_data;

   modport source (output valid, output target, output byte_address, output is_write,
                   output write_data, input ready);
   modport sink (input valid, input target, input byte_address, input is_write,
                 input write_data, output ready);
endinterface

FILE: rtl/core/kfpa_map.sv
module kfpa_map (
   input  logic [14:0]              char_code,
   input  logic [7:0]               row_select,
   input  logic                     ank_eight_dot,
   input  logic                     for_write,
   output kfpa_pkg::map_result_type result
);
   import kfpa_pkg::*;

   logic             half;
   logic [7:0]       jis1;
   logic [6:0]       jis2;
   logic             ank;
   logic [3:0]       row;
   logic [SUM_W-1:0] half_w;
   logic [SUM_W-1:0] mid;
   logic [SUM_W-1:0] hi;
   logic [SUM_W-1:0] lo;
   logic [SUM_W-1:0] sel3;
   logic [SUM_W-1:0] sel4;
   logic [SUM_W-1:0] base;
   logic [SUM_W-1:0] row_ofs;
   logic [SUM_W-1:0] total;

   always_comb begin
      // row bit 5 clear selects the right half
      half   = ~row_select[5];
      jis1   = {1'b0, char_code[6:0]} + JIS1_OFFSET;
      jis2   = char_code[14:8];
      ank    = (jis2 == 7'd0) && !half;
      half_w = {{(SUM_W-1){1'b0}}, half};
      mid    = {{(SUM_W-15){1'b0}}, jis2[6:5], 13'd0};
      hi     = {{(SUM_W-17){1'b0}}, jis2[6:5], 15'd0};
      lo     = {{(SUM_W-10){1'b0}}, jis2[4:0], 5'd0};
      sel3   = {{(SUM_W-13){1'b0}}, jis1[2:0], 10'd0};
      sel4   = {{(SUM_W-14){1'b0}}, jis1[3:0], 10'd0};

      result.target   = TGT_ROM;
      result.writable = 1'b0;

      if (ank) begin
         if (ank_eight_dot)
            base = ANK8_BASE + {{(SUM_W-11){1'b0}}, char_code[7:0], 3'd0};
         else
            base = ANK16_BASE + {{(SUM_W-12){1'b0}}, char_code[7:0], 4'd0};
      end else if (jis1 < 8'h28) begin
         base = half_w + mid + sel3 + lo;
      end else if (jis1 < 8'h30) begin
         base = half_w + NONKANJI_B + mid + sel3 + lo;
      end else if (jis1 < 8'h40) begin
         base = half_w + hi + sel4 + lo;
      end else if (jis1 < 8'h50) begin
         base = half_w + LEVEL1_HI + hi + sel4 + lo;
      end else if (jis1 < 8'h60) begin
         base = half_w + LEVEL2_BASE + hi + sel4 + lo;
      end else if (jis1 < 8'h70) begin
         base = half_w + LEVEL2_HI + hi + sel4 + lo;
      end else if (jis1 < 8'h76) begin
         base = half_w + LEVEL2_BASE + mid + sel3 + lo;
      end else if (jis1 < 8'h78) begin
         if (jis1 == 8'h77 && (jis2 == BLANK_JIS2A || jis2 == BLANK_JIS2B)) begin
            result.target = TGT_BLANK;
            base          = half_w;
         end else begin
            result.target   = TGT_BACKUP;
            result.writable = 1'b1;
            base = half_w + {{(SUM_W-13){1'b0}}, jis2[6:5], 11'd0}
                 + {{(SUM_W-11){1'b0}}, jis1[0], 10'd0} + lo;
         end
      end else begin
         // unassigned area: row offset alone
         base = '0;
      end

      if (!for_write && ank && ank_eight_dot)
         row = {1'b0, row_select[2:0]};
      else
         row = row_select[3:0];

      // two bytes per row except when the high byte is zero
      if (jis2 == 7'd0)
         row_ofs = {{(SUM_W-4){1'b0}}, row};
      else
         row_ofs = {{(SUM_W-5){1'b0}}, row, 1'b0};

      total               = base + row_ofs;
      result.byte_address = total[ADDR_W-1:0];
   end

endmodule

FILE: rtl/core/kanji_font_port_address_unit.sv
// From input accept to result valid, an item passes the input register, then the result register.
// Throughput: one item per cycle while the result is not stalled; a stalled result does not block
// acceptance of the next item while the input register is free.
// Code, row and 8-dot mode registers act on the item as it leaves the input register.
// Reset (synchronous, active high) clears both valid flags, the code, the row and the mode.
module kanji_font_port_address_unit (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic            csr_write_data,
   kfpa_req_if.sink        req_if,
   kfpa_rsp_if.source      rsp_if
);
   import kfpa_pkg::*;

   logic                  s0_valid_ff, s0_valid_in;
   op_type                s0_op_ff, s0_op_in;
   logic [7:0]            s0_data_ff, s0_data_in;
   logic [14:0]           char_code_ff, char_code_in;
   logic [7:0]            row_ff, row_in;
   logic                  ank8_ff, ank8_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_target_ff, rsp_target_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic                  rsp_write_ff, rsp_write_in;
   logic [7:0]            rsp_wdata_ff, rsp_wdata_in;
   logic                  out_enable;
   logic                  advance;
   logic                  produce;
   map_result_type        map_res;

   kfpa_map u_map (
      .char_code     (char_code_ff),
      .row_select    (row_ff),
      .ank_eight_dot (ank8_ff),
      .for_write     (s0_op_ff == OP_WRITE),
      .result        (map_res)
   );

   assign out_enable   = !rsp_valid_ff || rsp_if.ready;
   assign advance      = s0_valid_ff && out_enable;
   assign req_if.ready = !s0_valid_ff || out_enable;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.target       = rsp_target_ff;
   assign rsp_if.byte_address = rsp_addr_ff;
   assign rsp_if.is_write     = rsp_write_ff;
   assign rsp_if.write_data   = rsp_wdata_ff;

   always_comb begin
      s0_valid_in   = s0_valid_ff;
      s0_op_in      = s0_op_ff;
      s0_data_in    = s0_data_ff;
      char_code_in  = char_code_ff;
      row_in        = row_ff;
      ank8_in       = csr_write_enable ? csr_write_data : ank8_ff;
      produce       = 1'b0;
      rsp_write_in  = 1'b0;
      rsp_wdata_in  = 8'd0;

      if (req_if.ready) begin
         s0_valid_in = req_if.valid;
         if (req_if.valid) begin
            s0_op_in   = op_type'(req_if.operation);
            s0_data_in = req_if.data;
         end
      end

      if (advance) begin
         case (s0_op_ff)
            OP_CODE_LO: char_code_in = {char_code_ff[14:8], s0_data_ff};
            OP_CODE_HI: char_code_in = {s0_data_ff[6:0], char_code_ff[7:0]};
            OP_ROW:     row_in       = s0_data_ff;
            OP_READ:    produce      = 1'b1;
            OP_WRITE: begin
               // drop writes outside user glyphs
               produce      = map_res.writable;
               rsp_write_in = 1'b1;
               rsp_wdata_in = s0_data_ff;
            end
            default: produce = 1'b0;
         endcase
      end

      rsp_target_in = map_res.target;
      rsp_addr_in   = map_res.byte_address;
      rsp_valid_in  = out_enable ? produce : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         char_code_ff <= '0;
         row_ff       <= '0;
         ank8_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         char_code_ff <= char_code_in;
         row_ff       <= row_in;
         ank8_ff      <= ank8_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_op_ff   <= s0_op_in;
      s0_data_ff <= s0_data_in;
      if (produce) begin
         rsp_target_ff <= rsp_target_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_write_ff  <= rsp_write_in;
         rsp_wdata_ff  <= rsp_wdata_in;
      end
   end

endmodule

FILE: rtl/core/kfpa_checker.sv
module kfpa_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_target,
   input logic [kfpa_pkg::ADDR_W-1:0] rsp_byte_address,
   input logic                      rsp_is_write,
   input logic [7:0]                rsp_write_data
);
   import kfpa_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target)
         && $stable(rsp_byte_address) && $stable(rsp_is_write) && $stable(rsp_write_data))
      else $error("stalled result changed");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_write |-> rsp_write_data == 8'd0)
      else $error("read carries write data");

   a_write_backup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_write |-> rsp_target == TGT_BACKUP)
      else $error("write issued outside user glyph area");

endmodule

bind kanji_font_port_address_unit kfpa_checker u_kfpa_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_target       (rsp_if.target),
   .rsp_byte_address (rsp_if.byte_address),
   .rsp_is_write     (rsp_if.is_write),
   .rsp_write_data   (rsp_if.write_data)
);

FILE: bench/tb_top.sv
package kfpa_tb_pkg;
   import kfpa_pkg::*;

   typedef struct packed {
      logic [1:0]        target;
      logic [ADDR_W-1:0] byte_address;
      logic              is_write;
      logic [7:0]        write_data;
   } font_access_type;

   class font_access_board;
      font_access_type pending[$];
      logic            eight_dot;
      logic [14:0]     code_reg;
      logic [7:0]      row_reg;
      int              errors;
      int              items_taken;
      int              items_ignored;
      int              reads;
      int              writes_issued;
      int              writes_dropped;
      int              target_hits[3];

      function new();
         eight_dot = 1'b0;
         code_reg  = '0;
         row_reg   = '0;
      endfunction

      task report_mismatch(input string msg);
         errors++;
         if (errors <= 40)
            $display("[%0t] ERROR %s", $time, msg);
      endtask

      // Work out target and address for the current code; returns 1 if writable.
      function bit map_code(input bit for_write, output font_access_type acc);
         int unsigned half, jis1, jis2, stepw, rowi, mid, hi, lo, low_byte, addr;
         logic [1:0]  tgt;
         bit          ank, wr;
         half     = row_reg[5] ? 0 : 1;
         jis1     = code_reg[6:0] + 'h20;
         jis2     = code_reg[14:8];
         low_byte = code_reg[7:0];
         stepw    = (jis2 == 0) ? 1 : 2;
         ank      = (jis2 == 0) && (half == 0);
         mid      = (jis2 & 'h60) << 8;
         hi       = (jis2 & 'h60) << 10;
         lo       = (jis2 & 'h1f) << 5;
         tgt      = TGT_ROM;
         wr       = 1'b0;
         if (ank) begin
            addr = eight_dot ? ANK8_BASE + (low_byte << 3) : ANK16_BASE + (low_byte << 4);
         end else if (jis1 < 'h28) begin
            addr = half + mid + ((jis1 & 'h07) << 10) + lo;
         end else if (jis1 < 'h30) begin
            addr = half + NONKANJI_B + mid + ((jis1 & 'h07) << 10) + lo;
         end else if (jis1 < 'h40) begin
            addr = half + hi + ((jis1 & 'h0f) << 10) + lo;
         end else if (jis1 < 'h50) begin
            addr = half + LEVEL1_HI + hi + ((jis1 & 'h0f) << 10) + lo;
         end else if (jis1 < 'h60) begin
            addr = half + LEVEL2_BASE + hi + ((jis1 & 'h0f) << 10) + lo;
         end else if (jis1 < 'h70) begin
            addr = half + LEVEL2_HI + hi + ((jis1 & 'h0f) << 10) + lo;
         end else if (jis1 < 'h76) begin
            addr = half + LEVEL2_BASE + mid + ((jis1 & 'h07) << 10) + lo;
         end else if (jis1 < 'h78) begin
            if (jis1 == 'h77 && (jis2 == BLANK_JIS2A || jis2 == BLANK_JIS2B)) begin
               tgt  = TGT_BLANK;
               addr = half;
            end else begin
               tgt  = TGT_BACKUP;
               addr = half + ((jis2 & 'h60) << 6) + ((jis1 & 'h01) << 10) + lo;
               wr   = 1'b1;
            end
         end else begin
            addr = 0;
         end
         // 8-dot ANK rows wrap at 8 on reads only
         rowi = (!for_write && ank && eight_dot) ? (row_reg & 'h07) : (row_reg & 'h0f);
         addr = addr + stepw * rowi;
         acc.target       = tgt;
         acc.byte_address = ADDR_W'(addr);
         acc.is_write     = for_write;
         acc.write_data   = '0;
         return wr;
      endfunction

      function void note_item(input logic [2:0] op, input logic [7:0] value);
         font_access_type acc;
         if (op > OP_WRITE) begin
            items_ignored++;
            return;
         end
         items_taken++;
         case (op)
            OP_CODE_LO: code_reg[7:0]  = value;
            OP_CODE_HI: code_reg[14:8] = value[6:0];
            OP_ROW:     row_reg        = value;
            OP_READ: begin
               void'(map_code(1'b0, acc));
               pending.push_back(acc);
               reads++;
            end
            OP_WRITE: begin
               if (map_code(1'b1, acc)) begin
                  acc.write_data = value;
                  pending.push_back(acc);
                  writes_issued++;
               end else begin
                  writes_dropped++;
               end
            end
            default: ;
         endcase
      endfunction

      task check_access(input logic [1:0] target, input logic [ADDR_W-1:0] byte_address,
                        input logic is_write, input logic [7:0] write_data);
         font_access_type exp;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected access tgt=%0d addr=%h wr=%0b data=%h",
                                      target, byte_address, is_write, write_data));
            return;
         end
         exp = pending.pop_front();
         if (target !== exp.target)
            report_mismatch($sformatf("target got %0d expected %0d", target, exp.target));
         if (byte_address !== exp.byte_address)
            report_mismatch($sformatf("byte_address got %h expected %h",
                                      byte_address, exp.byte_address));
         if (is_write !== exp.is_write)
            report_mismatch($sformatf("is_write got %0b expected %0b", is_write, exp.is_write));
         if (write_data !== exp.write_data)
            report_mismatch($sformatf("write_data got %h expected %h",
                                      write_data, exp.write_data));
         if (exp.target < 3)
            target_hits[exp.target]++;
      endtask

      task check_drained();
         while (pending.size() != 0) begin
            report_mismatch($sformatf("access never seen: addr=%h",
                                      pending[0].byte_address));
            void'(pending.pop_front());
         end
      endtask
   endclass

endpackage

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kfpa_pkg::*;
   import kfpa_tb_pkg::*;

   localparam int         CYCLE_LIMIT    = 400000;
   localparam int         SETTLE_CYCLES  = 4;
   localparam int         PHASE_ITEMS    = 115;
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   // low 7 code bits that land in the user-glyph area (jis1 76) and the blank column (77)
   localparam logic [6:0] USER_CODE_LO   = 7'h56;
   localparam logic [6:0] BLANK_CODE_LO  = 7'h57;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;
   bit   quiet = 1'b0;
   int   cycles = 0;
   int   modes_written = 0;

   font_access_board board = new();

   kfpa_req_if req_bus ();
   kfpa_rsp_if rsp_bus ();

   kanji_font_port_address_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("kanji_font_port_address_unit: mismatch");
         $finish;
      end
   end

   // alternate spells with and without idling on both sides
   initial begin : calm_spells
      forever begin
         repeat ($urandom_range(40, 400)) @(posedge clock);
         quiet = !quiet;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_access(rsp_bus.target, rsp_bus.byte_address, rsp_bus.is_write,
                            rsp_bus.write_data);
   end

   initial begin : rsp_side
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 15);
         @(negedge clock);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [7:0] value);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.data      <= value;
      do @(posedge clock); while (!req_bus.ready);
      board.note_item(op, value);
   endtask

   // drop valid, wait for every access, then let the pipeline drain
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.eight_dot = value;
      modes_written++;
   endtask

   task automatic run_directed();
      send_item(OP_READ, 8'h00);          // reset code in the right half
      send_item(OP_CODE_LO, 8'hFF);
      send_item(OP_CODE_HI, 8'h00);
      send_item(OP_ROW, 8'h2F);           // left half, widest row
      send_item(OP_READ, 8'h00);          // ANK glyph
      send_item(OP_WRITE, 8'hA5);         // ANK is read-only
      send_item(OP_CODE_HI, 8'hFE);       // top bit dropped
      send_item(OP_CODE_LO, {1'b0, BLANK_CODE_LO});
      send_item(OP_READ, 8'h00);          // fixed blank
      send_item(OP_WRITE, 8'h5A);         // blank is never written
      send_item(OP_CODE_HI, 8'h7F);
      send_item(OP_ROW, 8'h00);           // right half
      send_item(OP_READ, 8'hFF);
      send_item(OP_CODE_LO, {1'b1, USER_CODE_LO});
      send_item(OP_CODE_HI, 8'h21);
      send_item(OP_WRITE, 8'h3C);         // user glyph store
      send_item(OP_ROW, 8'hFF);
      send_item(OP_WRITE, 8'hC3);
      send_item(OP_READ, 8'h00);
      send_item(OP_CODE_LO, 8'h7F);       // unassigned area
      send_item(OP_READ, 8'h00);
      send_item(OP_WRITE, 8'hFF);
      send_item(OP_SPARE_FIRST, 8'hFF);
      send_item(OP_SPARE_LAST, 8'h00);
   endtask

   task automatic run_random(input int count);
      int         goal;
      logic [7:0] lo_byte, hi_byte;
      goal = board.items_taken + count;
      while (board.items_taken < goal) begin
         if ($urandom_range(0, 9) < 8) begin
            lo_byte = 8'($urandom_range(0, 255));
            hi_byte = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
               0: hi_byte[6:0] = '0;
               1, 2: lo_byte[6:0] = USER_CODE_LO | 7'($urandom_range(0, 1));
               3: begin
                  lo_byte[6:0] = BLANK_CODE_LO;
                  hi_byte[6:0] = BLANK_JIS2A | 7'($urandom_range(0, 1));
               end
               default: ;
            endcase
            if ($urandom_range(0, 1)) begin
               send_item(OP_CODE_LO, lo_byte);
               send_item(OP_CODE_HI, hi_byte);
            end else begin
               send_item(OP_CODE_HI, hi_byte);
               send_item(OP_CODE_LO, lo_byte);
            end
            if ($urandom_range(0, 1))
               send_item(OP_ROW, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4))
               send_item($urandom_range(0, 1) ? OP_WRITE : OP_READ, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4))
               send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin : stimulus
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_CODE_LO;
      req_bus.data      = '0;
      csr_write_enable  = 1'b0;
      csr_write_data    = 1'b0;
      reset             = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      settle();
      set_mode(1'b1);
      run_directed();
      for (int phase = 0; phase < 5; phase++) begin
         settle();
         set_mode(phase[0]);
         run_random(PHASE_ITEMS);
      end
      settle();
      repeat (8) @(posedge clock);
      board.check_drained();

      $display("covered %0d items in %0d mode settings: %0d reads, %0d stores, %0d refused",
               board.items_taken, modes_written, board.reads, board.writes_issued,
               board.writes_dropped);
      $display("accesses by target: rom %0d, backup %0d, blank %0d; %0d spare ops ignored",
               board.target_hits[TGT_ROM], board.target_hits[TGT_BACKUP],
               board.target_hits[TGT_BLANK], board.items_ignored);
      if (board.errors == 0) begin
         $display("kanji_font_port_address_unit: match");
      end else begin
         $display("kanji_font_port_address_unit: mismatch");
      end
      $finish;
   end

endmodule
